FILE: rtl/range_kth_smallest_engine_top_defines.svh
`ifndef RANGE_KTH_SMALLEST_ENGINE_TOP_DEFINES_SVH
`define RANGE_KTH_SMALLEST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define RKS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define RKS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rks_pkg.sv
`default_nettype none

package rks_pkg;

  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int VAL_PORT_W = 16;
  localparam int POS_PORT_W = 11;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_K     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AROOT,
    S_AWALK,
    S_QROOT,
    S_QNODE,
    S_QLEFT,
    S_QRIGHT,
    S_EMIT
  } rks_state_t;

endpackage

`default_nettype wire

FILE: rtl/rks_mem.sv
`default_nettype none

module rks_mem #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_a_r;
  logic [WIDTH-1:0] q_b_r;
  logic             zero_a_r;
  logic             zero_b_r;

  // entry zero is never written and always reads as the empty word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a_r    <= mem[raddr_a];
    q_b_r    <= mem[raddr_b];
    zero_a_r <= (raddr_a == '0);
    zero_b_r <= (raddr_b == '0);
  end

  assign rdata_a = zero_a_r ? '0 : q_a_r;
  assign rdata_b = zero_b_r ? '0 : q_b_r;

endmodule

`default_nettype wire

FILE: rtl/range_kth_smallest_engine_top.sv
// Accept to out_tvalid: append goes S_AROOT, S_AWALK once per tree level, S_EMIT; query goes
// S_QROOT, S_QNODE, S_QLEFT/S_QRIGHT, S_EMIT; clear, rejected and unknown operations S_EMIT.
// Throughput: one transaction at a time, the next one accepted as S_EMIT registers the result;
// a held result stalls the next one's result in S_EMIT until out_tready.
// The walk steps one tree level per cycle through the node memory (two read ports), and a query
// adds an S_QRIGHT step per right turn above the leaf level. Reset clears control state only;
// node zero and version zero read as empty by address decode, so no clearing pass is needed.
`default_nettype none
`include "range_kth_smallest_engine_top_defines.svh"

module range_kth_smallest_engine_top #(
  parameter int MAX_ITEMS  = 1024,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // item_value[15:0], range_first[26:16], range_last[37:27], rank_k[48:38], zero pad
  input  wire logic [rks_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode[1:0]
  input  wire logic [rks_pkg::OP_W-1:0]          in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // answer_value[15:0], item_index[26:16], zero pad
  output logic      [rks_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic      [rks_pkg::ST_W-1:0]          out_tuser
);

  localparam int IDX_W      = $clog2(MAX_ITEMS + 1);
  localparam int CNT_W      = IDX_W;
  localparam int NODE_DEPTH = 1 + MAX_ITEMS * (VALUE_BITS + 1);
  localparam int NODE_W     = $clog2(NODE_DEPTH);
  localparam int NW         = 2 * NODE_W + CNT_W;
  localparam int ROOT_DEPTH = MAX_ITEMS + 1;
  localparam int RA_W       = $clog2(ROOT_DEPTH);
  localparam int LVL_W      = $clog2(VALUE_BITS + 1);
  localparam int ANS_XW     = (VALUE_BITS > rks_pkg::VAL_PORT_W) ? VALUE_BITS
                                                                 : rks_pkg::VAL_PORT_W;
  localparam int XW         = (IDX_W > rks_pkg::POS_PORT_W) ? IDX_W : rks_pkg::POS_PORT_W;
  localparam int CW         = XW + 1;

  rks_pkg::rks_state_t state_r, state_nxt;

  logic [IDX_W-1:0]      len_r, len_nxt;
  logic [NODE_W-1:0]     used_r, used_nxt;
  logic [NODE_W-1:0]     cur_r, cur_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] ans_r, ans_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [NODE_W-1:0]     ur_r, ur_nxt;
  logic [NODE_W-1:0]     vr_r, vr_nxt;
  logic [rks_pkg::ST_W-1:0] res_st_r, res_st_nxt;
  logic [IDX_W-1:0]      res_idx_r, res_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [rks_pkg::VAL_PORT_W-1:0] out_ans_r, out_ans_nxt;
  logic [rks_pkg::POS_PORT_W-1:0] out_idx_r, out_idx_nxt;
  logic [rks_pkg::ST_W-1:0]       out_st_r, out_st_nxt;

  logic              node_we;
  logic [NODE_W-1:0] node_waddr;
  logic [NW-1:0]     node_wdata;
  logic [NODE_W-1:0] node_ra_a;
  logic [NODE_W-1:0] node_ra_b;
  logic [NW-1:0]     node_rd_a;
  logic [NW-1:0]     node_rd_b;

  logic              root_we;
  logic [RA_W-1:0]   root_waddr;
  logic [NODE_W-1:0] root_wdata;
  logic [RA_W-1:0]   root_ra_a;
  logic [RA_W-1:0]   root_ra_b;
  logic [NODE_W-1:0] root_rd_a;
  logic [NODE_W-1:0] root_rd_b;

  logic [rks_pkg::OP_W-1:0]       op;
  logic [rks_pkg::VAL_PORT_W-1:0] in_val;
  logic [rks_pkg::POS_PORT_W-1:0] in_first;
  logic [rks_pkg::POS_PORT_W-1:0] in_last;
  logic [rks_pkg::POS_PORT_W-1:0] in_k;
  logic [ANS_XW-1:0]  val_ext;
  logic [ANS_XW-1:0]  ans_ext;
  logic [XW-1:0]      idx_ext;
  logic [CW-1:0]      f_w, l_w, k_w, n_w;
  logic               bad_range;
  logic               bad_k;
  logic [NODE_W-1:0]  la, ra, lb, rb;
  logic [CNT_W-1:0]   ca, cb, cnt_diff;
  logic               out_free;

  assign op       = in_tuser;
  assign in_val   = in_tdata[15:0];
  assign in_first = in_tdata[26:16];
  assign in_last  = in_tdata[37:27];
  assign in_k     = in_tdata[48:38];

  assign val_ext  = ANS_XW'(in_val);
  assign ans_ext  = ANS_XW'(ans_r);
  assign idx_ext  = XW'(res_idx_r);

  assign f_w = CW'(in_first);
  assign l_w = CW'(in_last);
  assign k_w = CW'(in_k);
  assign n_w = CW'(len_r);
  assign bad_range = (f_w == '0) || (l_w > n_w) || (f_w > l_w);
  assign bad_k     = (k_w == '0) || (k_w > (l_w - f_w + CW'(1)));

  assign la = node_rd_a[NODE_W-1:0];
  assign ra = node_rd_a[2*NODE_W-1:NODE_W];
  assign ca = node_rd_a[NW-1:2*NODE_W];
  assign lb = node_rd_b[NODE_W-1:0];
  assign rb = node_rd_b[2*NODE_W-1:NODE_W];
  assign cb = node_rd_b[NW-1:2*NODE_W];
  assign cnt_diff = cb - ca;

  assign out_free = !out_valid_r || out_tready;

  rks_mem #(
    .DEPTH (NODE_DEPTH),
    .WIDTH (NW)
  ) u_node_mem (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .raddr_a (node_ra_a),
    .raddr_b (node_ra_b),
    .rdata_a (node_rd_a),
    .rdata_b (node_rd_b)
  );

  rks_mem #(
    .DEPTH (ROOT_DEPTH),
    .WIDTH (NODE_W)
  ) u_root_mem (
    .clk     (clk),
    .we      (root_we),
    .waddr   (root_waddr),
    .wdata   (root_wdata),
    .raddr_a (root_ra_a),
    .raddr_b (root_ra_b),
    .rdata_a (root_rd_a),
    .rdata_b (root_rd_b)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    used_nxt      = used_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    ans_nxt       = ans_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    ur_nxt        = ur_r;
    vr_nxt        = vr_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ans_nxt   = out_ans_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    node_we       = 1'b0;
    node_waddr    = cur_r;
    node_wdata    = '0;
    node_ra_a     = '0;
    node_ra_b     = '0;
    root_we       = 1'b0;
    root_waddr    = RA_W'(len_r + IDX_W'(1));
    root_wdata    = used_r + NODE_W'(1);
    root_ra_a     = '0;
    root_ra_b     = '0;

    case (state_r)
      rks_pkg::S_IDLE: begin
        if (in_tvalid) begin
          ans_nxt     = '0;
          res_st_nxt  = rks_pkg::ST_OK;
          res_idx_nxt = len_r;
          lvl_nxt     = LVL_W'(VALUE_BITS);
          state_nxt   = rks_pkg::S_EMIT;
          case (op)
            rks_pkg::OP_APPEND: begin
              if (len_r >= IDX_W'(MAX_ITEMS)) begin
                res_st_nxt = rks_pkg::ST_FULL;
              end else begin
                root_ra_a = RA_W'(len_r);
                root_we   = 1'b1;
                cur_nxt   = used_r + NODE_W'(1);
                val_nxt   = val_ext[VALUE_BITS-1:0];
                state_nxt = rks_pkg::S_AROOT;
              end
            end
            rks_pkg::OP_QUERY: begin
              res_idx_nxt = '0;
              if (bad_range) begin
                res_st_nxt = rks_pkg::ST_BAD_RANGE;
              end else if (bad_k) begin
                res_st_nxt = rks_pkg::ST_BAD_K;
              end else begin
                root_ra_a = RA_W'(f_w - CW'(1));
                root_ra_b = RA_W'(l_w);
                k_nxt     = CNT_W'(in_k);
                state_nxt = rks_pkg::S_QROOT;
              end
            end
            rks_pkg::OP_CLEAR: begin
              len_nxt     = '0;
              used_nxt    = '0;
              res_idx_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      rks_pkg::S_AROOT: begin
        node_ra_a = root_rd_a;
        state_nxt = rks_pkg::S_AWALK;
      end

      rks_pkg::S_AWALK: begin
        node_we    = 1'b1;
        node_waddr = cur_r;
        if (lvl_r != '0) begin
          if (val_r[VALUE_BITS-1]) begin
            node_wdata = {ca + CNT_W'(1), cur_r + NODE_W'(1), la};
            node_ra_a  = ra;
          end else begin
            node_wdata = {ca + CNT_W'(1), ra, cur_r + NODE_W'(1)};
            node_ra_a  = la;
          end
          cur_nxt = cur_r + NODE_W'(1);
          val_nxt = val_r << 1;
          lvl_nxt = lvl_r - LVL_W'(1);
        end else begin
          node_wdata  = {ca + CNT_W'(1), ra, la};
          used_nxt    = cur_r;
          len_nxt     = len_r + IDX_W'(1);
          res_idx_nxt = len_r + IDX_W'(1);
          state_nxt   = rks_pkg::S_EMIT;
        end
      end

      rks_pkg::S_QROOT: begin
        node_ra_a = root_rd_a;
        node_ra_b = root_rd_b;
        state_nxt = rks_pkg::S_QNODE;
      end

      rks_pkg::S_QNODE: begin
        ur_nxt    = ra;
        vr_nxt    = rb;
        node_ra_a = la;
        node_ra_b = lb;
        state_nxt = rks_pkg::S_QLEFT;
      end

      rks_pkg::S_QLEFT: begin
        if (k_r <= cnt_diff) begin
          ans_nxt = ans_r << 1;
          if (lvl_r == LVL_W'(1)) begin
            state_nxt = rks_pkg::S_EMIT;
          end else begin
            ur_nxt    = ra;
            vr_nxt    = rb;
            node_ra_a = la;
            node_ra_b = lb;
            lvl_nxt   = lvl_r - LVL_W'(1);
          end
        end else begin
          k_nxt   = k_r - cnt_diff;
          ans_nxt = (ans_r << 1) | VALUE_BITS'(1);
          if (lvl_r == LVL_W'(1)) begin
            state_nxt = rks_pkg::S_EMIT;
          end else begin
            node_ra_a = ur_r;
            node_ra_b = vr_r;
            state_nxt = rks_pkg::S_QRIGHT;
          end
        end
      end

      rks_pkg::S_QRIGHT: begin
        ur_nxt    = ra;
        vr_nxt    = rb;
        node_ra_a = la;
        node_ra_b = lb;
        lvl_nxt   = lvl_r - LVL_W'(1);
        state_nxt = rks_pkg::S_QLEFT;
      end

      rks_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ans_nxt   = ans_ext[rks_pkg::VAL_PORT_W-1:0];
          out_idx_nxt   = idx_ext[rks_pkg::POS_PORT_W-1:0];
          out_st_nxt    = res_st_r;
          state_nxt     = rks_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rks_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rks_pkg::S_IDLE;
      len_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    val_r     <= val_nxt;
    ans_r     <= ans_nxt;
    lvl_r     <= lvl_nxt;
    k_r       <= k_nxt;
    ur_r      <= ur_nxt;
    vr_r      <= vr_nxt;
    res_st_r  <= res_st_nxt;
    res_idx_r <= res_idx_nxt;
    out_ans_r <= out_ans_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_tready  = (state_r == rks_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = rks_pkg::OUT_DATA_W'({out_idx_r, out_ans_r});
  assign out_tuser  = out_st_r;

  `RKS_ASSERT_SAME(a_len_bound, 1'b1, len_r <= IDX_W'(MAX_ITEMS),
                   "sequence length past store size")
  `RKS_ASSERT_SAME(a_alloc_bound, state_r == rks_pkg::S_AWALK,
                   cur_r <= NODE_W'(NODE_DEPTH - 1), "node allocation past end of store")
  `RKS_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != rks_pkg::S_IDLE,
                   "accepted transaction left no work")
  `RKS_ASSERT_SAME(a_err_zero, out_valid_r && (out_st_r != rks_pkg::ST_OK),
                   out_ans_r == '0, "error result carries a value")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 16;
  localparam int NODE_CAP   = 1 + MAX_ITEMS * (VALUE_BITS + 1);
  localparam int LONG_HOLD  = 400;
  localparam int WATCHDOG   = 3000;
  localparam int TAIL_WAIT  = 4 + 2 * VALUE_BITS + 8;

  localparam logic [rks_pkg::OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [rks_pkg::OP_W-1:0]       op;
    logic [rks_pkg::VAL_PORT_W-1:0] value;
    logic [rks_pkg::POS_PORT_W-1:0] first;
    logic [rks_pkg::POS_PORT_W-1:0] last;
    logic [rks_pkg::POS_PORT_W-1:0] k;
  } op_item_t;

  typedef struct packed {
    logic [rks_pkg::VAL_PORT_W-1:0] answer;
    logic [rks_pkg::POS_PORT_W-1:0] index;
    logic [rks_pkg::ST_W-1:0]       status;
  } answer_t;

  typedef struct packed {
    op_item_t stim;
    logic     typed;
    answer_t  want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [rks_pkg::IN_DATA_W-1:0] in_tdata;
  logic [rks_pkg::OP_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [rks_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [rks_pkg::ST_W-1:0] out_tuser;

  // persistent counting tree, node 0 is the shared empty node
  int unsigned tree_left  [NODE_CAP];
  int unsigned tree_right [NODE_CAP];
  int unsigned tree_count [NODE_CAP];
  int unsigned version_root [MAX_ITEMS + 1];
  int unsigned nodes_taken = 0;
  int unsigned seq_len = 0;
  int unsigned longest_seq = 0;

  answer_t pending_answers[$];
  plan_row_t plan[$];
  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int status_tally[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  range_kth_smallest_engine_top #(
    .MAX_ITEMS (MAX_ITEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clone_node(int unsigned src);
    nodes_taken++;
    tree_left[nodes_taken]  = tree_left[src];
    tree_right[nodes_taken] = tree_right[src];
    tree_count[nodes_taken] = tree_count[src] + 1;
    return nodes_taken;
  endfunction

  function automatic answer_t predict_answer(op_item_t it);
    answer_t r;
    int unsigned prev, cur, fresh, u, v, k, cnt, lo, hi;
    int b;
    r = '0;
    case (it.op)
      rks_pkg::OP_APPEND: begin
        if (seq_len >= MAX_ITEMS) begin
          r.status = rks_pkg::ST_FULL;
        end else begin
          prev = version_root[seq_len];
          cur = clone_node(prev);
          version_root[seq_len + 1] = cur;
          for (b = VALUE_BITS - 1; b >= 0; b--) begin
            prev = it.value[b] ? tree_right[prev] : tree_left[prev];
            fresh = clone_node(prev);
            if (it.value[b]) tree_right[cur] = fresh;
            else tree_left[cur] = fresh;
            cur = fresh;
          end
          seq_len++;
          if (seq_len > longest_seq) longest_seq = seq_len;
        end
        r.index = rks_pkg::POS_PORT_W'(seq_len);
      end
      rks_pkg::OP_QUERY: begin
        lo = 32'(it.first);
        hi = 32'(it.last);
        k = 32'(it.k);
        if (lo == 0 || hi > seq_len || lo > hi) begin
          r.status = rks_pkg::ST_BAD_RANGE;
        end else if (k == 0 || k > hi - lo + 1) begin
          r.status = rks_pkg::ST_BAD_K;
        end else begin
          u = version_root[lo - 1];
          v = version_root[hi];
          for (b = VALUE_BITS - 1; b >= 0; b--) begin
            cnt = tree_count[tree_left[v]] - tree_count[tree_left[u]];
            if (k <= cnt) begin
              u = tree_left[u];
              v = tree_left[v];
            end else begin
              k -= cnt;
              r.answer[b] = 1'b1;
              u = tree_right[u];
              v = tree_right[v];
            end
          end
        end
      end
      rks_pkg::OP_CLEAR: begin
        nodes_taken = 0;
        seq_len = 0;
        version_root[0] = 0;
      end
      default: begin
        r.index = rks_pkg::POS_PORT_W'(seq_len);
      end
    endcase
    return r;
  endfunction

  function automatic op_item_t mk(logic [rks_pkg::OP_W-1:0] op,
                                  logic [rks_pkg::VAL_PORT_W-1:0] value,
                                  logic [rks_pkg::POS_PORT_W-1:0] first,
                                  logic [rks_pkg::POS_PORT_W-1:0] last,
                                  logic [rks_pkg::POS_PORT_W-1:0] k);
    op_item_t it;
    it.op = op;
    it.value = value;
    it.first = first;
    it.last = last;
    it.k = k;
    return it;
  endfunction

  function automatic logic [rks_pkg::VAL_PORT_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return rks_pkg::VAL_PORT_W'($urandom_range(0, 15));
      1: return 16'hFFFF - rks_pkg::VAL_PORT_W'($urandom_range(0, 15));
      default: return rks_pkg::VAL_PORT_W'($urandom);
    endcase
  endfunction

  function automatic op_item_t random_append();
    return mk(rks_pkg::OP_APPEND, random_value(), rks_pkg::POS_PORT_W'($urandom),
              rks_pkg::POS_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom));
  endfunction

  function automatic op_item_t random_query();
    op_item_t q;
    int unsigned lo, hi, span, pick;
    q = mk(rks_pkg::OP_QUERY, rks_pkg::VAL_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom),
           rks_pkg::POS_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom));
    pick = $urandom_range(0, 99);
    if (seq_len != 0 && pick < 85) begin
      lo = $urandom_range(1, seq_len);
      hi = $urandom_range(lo, seq_len);
      span = hi - lo + 1;
      q.first = rks_pkg::POS_PORT_W'(lo);
      q.last = rks_pkg::POS_PORT_W'(hi);
      if (pick < 75) begin
        case ($urandom_range(0, 5))
          0: q.k = rks_pkg::POS_PORT_W'(1);
          1: q.k = rks_pkg::POS_PORT_W'(span);
          default: q.k = rks_pkg::POS_PORT_W'($urandom_range(1, span));
        endcase
      end else begin
        q.k = $urandom_range(0, 1) ? '0 : rks_pkg::POS_PORT_W'($urandom_range(span + 1, 2047));
      end
    end else if (pick < 95) begin
      case ($urandom_range(0, 2))
        0: q.first = '0;
        1: q.last = rks_pkg::POS_PORT_W'(seq_len + $urandom_range(1, 8));
        default: begin
          q.last = rks_pkg::POS_PORT_W'($urandom_range(1, 2046));
          q.first = q.last + 1'b1;
        end
      endcase
    end
    return q;
  endfunction

  function automatic op_item_t random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) return random_append();
    if (pick < 94) return random_query();
    if (pick < 97) return mk(rks_pkg::OP_CLEAR, rks_pkg::VAL_PORT_W'($urandom),
                             rks_pkg::POS_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom),
                             rks_pkg::POS_PORT_W'($urandom));
    return mk(OP_NOP, rks_pkg::VAL_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom),
              rks_pkg::POS_PORT_W'($urandom), rks_pkg::POS_PORT_W'($urandom));
  endfunction

  task automatic add_row(logic [rks_pkg::OP_W-1:0] op, logic [rks_pkg::VAL_PORT_W-1:0] value,
                         logic [rks_pkg::POS_PORT_W-1:0] first,
                         logic [rks_pkg::POS_PORT_W-1:0] last,
                         logic [rks_pkg::POS_PORT_W-1:0] k, logic typed,
                         logic [rks_pkg::VAL_PORT_W-1:0] answer,
                         logic [rks_pkg::POS_PORT_W-1:0] index,
                         logic [rks_pkg::ST_W-1:0] status);
    plan_row_t row;
    row.stim = mk(op, value, first, last, k);
    row.typed = typed;
    row.want.answer = answer;
    row.want.index = index;
    row.want.status = status;
    plan.insert(plan.size(), row);
  endtask

  task automatic run_item(op_item_t it, logic typed = 1'b0, answer_t want = '0);
    answer_t got;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata <= {7'd0, it.k, it.last, it.first, it.value};
    in_tuser <= it.op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    got = predict_answer(it);
    items_sent++;
    status_tally[got.status]++;
    pending_answers.insert(pending_answers.size(), typed ? want : got);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // result sink: random stalls, one long hold on request
  initial begin : sink
    int gap;
    bit held_done;
    held_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held_done) begin
        held_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 5);
        repeat (gap) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("result with nothing pending: answer %0d index %0d status %0d",
                             out_tdata[15:0], out_tdata[26:16], out_tuser));
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[15:0] !== want.answer || out_tdata[26:16] !== want.index ||
            out_tuser !== want.status) begin
          flag_error($sformatf("answer %0d/%0d index %0d/%0d status %0d/%0d (exp/act)",
                               want.answer, out_tdata[15:0], want.index, out_tdata[26:16],
                               want.status, out_tuser));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= rks_pkg::OP_APPEND;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd1,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_APPEND, 16'h0000, 11'd0,   11'd0,   11'd0,   1'b1,
            16'h0000, 11'd1, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_APPEND, 16'hFFFF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b1,
            16'h0000, 11'd2, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd0,   11'd1,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd3,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd2,   11'd1,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd2,   11'd0,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_K);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd2,   11'd3,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_K);
    add_row(rks_pkg::OP_QUERY,  16'hFFFF, 11'd1,   11'd2,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd2,   11'd2,   1'b1,
            16'hFFFF, 11'd0, rks_pkg::ST_OK);
    add_row(OP_NOP,             16'hFFFF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b1,
            16'h0000, 11'd2, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'hFFFF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd0,   11'd0,   11'd0,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_APPEND, 16'h8000, 11'h7FF, 11'h000, 11'h7FF, 1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_APPEND, 16'h7FFF, 11'h000, 11'h7FF, 11'h000, 1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_APPEND, 16'h8000, 11'd0,   11'd0,   11'd0,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_APPEND, 16'h0001, 11'd0,   11'd0,   11'd0,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd6,   11'd3,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd3,   11'd5,   11'd2,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd2,   11'd6,   11'd5,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd4,   11'd4,   11'd1,   1'b0,
            '0, '0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_CLEAR,  16'hFFFF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b1,
            16'h0000, 11'd0, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd1,   11'd1,   1'b1,
            16'h0000, 11'd0, rks_pkg::ST_BAD_RANGE);
    add_row(rks_pkg::OP_APPEND, 16'h5A5A, 11'd0,   11'd0,   11'd0,   1'b1,
            16'h0000, 11'd1, rks_pkg::ST_OK);
    add_row(rks_pkg::OP_QUERY,  16'h0000, 11'd1,   11'd1,   11'd1,   1'b1,
            16'h5A5A, 11'd0, rks_pkg::ST_OK);

    foreach (plan[i]) run_item(plan[i].stim, plan[i].typed, plan[i].want);

    for (i = 0; i < 330; i++) run_item(random_item());

    // stall the result side while the input keeps offering
    hold_req = 1'b1;
    for (i = 0; i < 20; i++) run_item(random_item());
    drain();

    // fill the store, then hit it while full
    run_item(mk(rks_pkg::OP_CLEAR, '0, '0, '0, '0));
    while (seq_len < MAX_ITEMS) begin
      if ($urandom_range(0, 19) == 0) run_item(random_query());
      else run_item(random_append());
    end
    for (i = 0; i < 6; i++) run_item(random_append());
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1, 11'd1024, 11'd1));
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1, 11'd1024, 11'd1024));
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1, 11'd1024, 11'd512));
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1, 11'd1024, 11'd1025));
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1, 11'd1025, 11'd1));
    run_item(mk(rks_pkg::OP_QUERY, '0, 11'd1024, 11'd1024, 11'd1));
    run_item(mk(OP_NOP, '0, '0, '0, '0));
    for (i = 0; i < 20; i++) run_item(random_query());
    drain();

    calm = 1'b1;
    for (i = 0; i < 120; i++) run_item(random_item());
    in_tvalid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("summary: %0d transactions sent, %0d results checked, longest sequence %0d",
             items_sent, results_checked, longest_seq);
    $display("summary: %0d ok, %0d bad range, %0d bad k, %0d dropped on a full store",
             status_tally[rks_pkg::ST_OK], status_tally[rks_pkg::ST_BAD_RANGE],
             status_tally[rks_pkg::ST_BAD_K], status_tally[rks_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
